### rtl/sdm_pkg.sv
// Package for the SPI datagram master: transfer structs, opcodes, phase codes
// and reset constants. No dependencies.
`default_nettype none

package sdm_pkg;

    localparam int CS_W            = 5;
    localparam int NUM_DEVICES_DEF = 5;
    localparam int FRAME_BITS_DEF  = 40;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CS_W-1:0]       ALL_CS         = '1;
    localparam logic [15:0]           DELAY_RESET    = 16'd100;
    localparam logic [2:0]            ATTEMPTS_RESET = 3'd3;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_VERIFY   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DELAY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'b1;

    typedef enum logic [11:0] {
        PH_IDLE   = 12'b0000_0000_0001,
        PH_DESEL  = 12'b0000_0000_0010,
        PH_CSLOW  = 12'b0000_0000_0100,
        PH_SLOW   = 12'b0000_0000_1000,
        PH_HIGH_A = 12'b0000_0001_0000,
        PH_HIGH_B = 12'b0000_0010_0000,
        PH_TAIL   = 12'b0000_0100_0000,
        PH_RISE_A = 12'b0000_1000_0000,
        PH_RISE_B = 12'b0001_0000_0000,
        PH_GAP_A  = 12'b0010_0000_0000,
        PH_GAP_B  = 12'b0100_0000_0000,
        PH_RETRY  = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  opcode;
        logic [2:0]  device;
        logic [6:0]  reg_addr;
        logic [31:0] write_value;
        logic [31:0] cmp_mask;
        logic        miso;
    } t_in_item;

    typedef struct packed {
        logic            sclk;
        logic            mosi;
        logic [CS_W-1:0] cs_n;
        logic            busy_res;
        logic            done_res;
        logic [31:0]     read_value;
        logic [7:0]      status_byte;
        logic            verify_ok;
        logic [2:0]      attempts_used;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/sdm_core.sv
// Phase sequencer of the SPI datagram master: advances one tick per step and
// forms that tick's pins and result fields. Depends on sdm_pkg.
`default_nettype none

module sdm_core
    import sdm_pkg::*;
#(
    parameter int NUM_DEVICES = NUM_DEVICES_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    input  wire logic [15:0] i_bit_delay,
    input  wire logic [2:0]  i_max_attempts,
    output t_out_item      o_result
);

    localparam int DATA_BITS = FRAME_BITS - 8;
    localparam int BIT_W     = $clog2(FRAME_BITS);
    localparam logic [BIT_W-1:0]      LAST_BIT = BIT_W'(FRAME_BITS - 1);
    localparam logic [FRAME_BITS-1:0] DMASK    = {8'd0, {DATA_BITS{1'b1}}};

    function automatic logic [FRAME_BITS-1:0] frame_word(
        input logic [6:0]  addr,
        input logic [31:0] value,
        input logic        is_write
    );
        logic [FRAME_BITS-1:0] abyte;
        logic [FRAME_BITS-1:0] data;
        abyte = FRAME_BITS'({is_write, addr}) << DATA_BITS;
        data  = is_write ? (FRAME_BITS'(value) & DMASK) : '0;
        return abyte | data;
    endfunction

    t_phase                r_phase, n_phase;
    logic [15:0]           r_delay, n_delay;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [1:0]            r_frame, n_frame;
    logic [FRAME_BITS-1:0] r_shift_out, n_shift_out;
    logic [FRAME_BITS-1:0] r_shift_in, n_shift_in;
    logic [2:0]            r_attempt, n_attempt;
    logic [1:0]            r_op, n_op;
    logic [2:0]            r_dev, n_dev;
    logic [6:0]            r_addr, n_addr;
    logic [31:0]           r_value, n_value;
    logic [31:0]           r_mask, n_mask;
    logic [31:0]           r_rd_value, n_rd_value;
    logic [7:0]            r_status, n_status;
    logic                  r_ok, n_ok;
    logic [2:0]            r_att_used, n_att_used;

    logic [15:0]     dly;
    logic [15:0]     delay_sum;
    logic [2:0]      lim;
    logic [CS_W-1:0] sel;
    logic            cur_bit;
    logic [31:0]     payload;
    logic            frame_done;
    logic            do_finish;
    logic            fin_ok;
    logic            fin_set_att;

    always_comb begin
        n_phase     = r_phase;
        n_delay     = r_delay;
        n_bit       = r_bit;
        n_frame     = r_frame;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_attempt   = r_attempt;
        n_op        = r_op;
        n_dev       = r_dev;
        n_addr      = r_addr;
        n_value     = r_value;
        n_mask      = r_mask;
        n_rd_value  = r_rd_value;
        n_status    = r_status;
        n_ok        = r_ok;
        n_att_used  = r_att_used;

        dly         = (i_bit_delay == 16'd0) ? 16'd1 : i_bit_delay;
        lim         = (i_max_attempts == 3'd0) ? 3'd1 : i_max_attempts;
        sel         = ALL_CS;
        cur_bit     = 1'b0;
        delay_sum   = '0;
        payload     = '0;
        frame_done  = 1'b0;
        do_finish   = 1'b0;
        fin_ok      = 1'b1;
        fin_set_att = 1'b0;

        o_result          = '0;
        o_result.sclk     = 1'b1;
        o_result.mosi     = 1'b0;
        o_result.cs_n     = ALL_CS;

        if (r_phase == PH_IDLE && i_item.start_req && i_item.opcode != OP_RESERVED) begin
            n_op        = i_item.opcode;
            n_dev       = i_item.device;
            n_addr      = i_item.reg_addr;
            n_value     = i_item.write_value;
            n_mask      = i_item.cmp_mask;
            n_attempt   = '0;
            n_frame     = '0;
            n_delay     = '0;
            n_shift_out = frame_word(i_item.reg_addr, i_item.write_value,
                                     i_item.opcode != OP_READ);
            n_shift_in  = '0;
            n_bit       = '0;
            n_phase     = PH_DESEL;
        end

        if (n_phase != PH_IDLE) begin
            o_result.busy_res = 1'b1;
            if (int'(n_dev) < NUM_DEVICES && int'(n_dev) < CS_W) begin
                sel = ALL_CS & ~(CS_W'(1) << n_dev);
            end
            cur_bit = n_shift_out[LAST_BIT - n_bit];
            case (n_phase)
                PH_CSLOW: o_result.cs_n = sel;
                PH_SLOW: begin
                    o_result.cs_n = sel;
                    o_result.sclk = 1'b0;
                    o_result.mosi = cur_bit;
                end
                PH_HIGH_A, PH_HIGH_B: begin
                    o_result.cs_n = sel;
                    o_result.mosi = cur_bit;
                end
                PH_TAIL: begin
                    o_result.cs_n = sel;
                    o_result.mosi = n_shift_out[0];
                end
                PH_RISE_A, PH_RISE_B, PH_GAP_A, PH_GAP_B: o_result.mosi = n_shift_out[0];
                default: ;
            endcase

            delay_sum = 16'(n_delay + 16'd1);
            if (delay_sum >= dly) begin
                n_delay = '0;
                case (n_phase)
                    PH_DESEL:  n_phase = PH_CSLOW;
                    PH_CSLOW:  n_phase = PH_SLOW;
                    PH_SLOW:   n_phase = PH_HIGH_A;
                    PH_HIGH_A: begin
                        n_shift_in = {n_shift_in[FRAME_BITS-2:0], i_item.miso};
                        n_phase    = PH_HIGH_B;
                    end
                    PH_HIGH_B: begin
                        if (n_bit >= LAST_BIT) begin
                            n_phase = PH_TAIL;
                        end else begin
                            n_bit   = n_bit + BIT_W'(1);
                            n_phase = PH_SLOW;
                        end
                    end
                    PH_TAIL:   n_phase = PH_RISE_A;
                    PH_RISE_A: n_phase = PH_RISE_B;
                    PH_RISE_B: frame_done = 1'b1;
                    PH_GAP_A:  n_phase = PH_GAP_B;
                    PH_GAP_B: begin
                        n_frame     = 2'd1;
                        n_shift_out = frame_word(n_addr, n_value, 1'b0);
                        n_shift_in  = '0;
                        n_bit       = '0;
                        n_phase     = PH_DESEL;
                    end
                    PH_RETRY: begin
                        n_frame     = 2'd0;
                        n_shift_out = frame_word(n_addr, n_value, 1'b1);
                        n_shift_in  = '0;
                        n_bit       = '0;
                        n_phase     = PH_DESEL;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                n_delay = delay_sum;
            end
        end

        payload = 32'(n_shift_in & DMASK);

        if (frame_done) begin
            case (n_op)
                OP_WRITE: do_finish = 1'b1;
                OP_READ: begin
                    if (n_frame == 2'd0) begin
                        n_frame     = 2'd1;
                        n_shift_out = frame_word(n_addr, n_value, 1'b0);
                        n_shift_in  = '0;
                        n_bit       = '0;
                        n_phase     = PH_DESEL;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    if (n_frame == 2'd0) begin
                        n_phase = PH_GAP_A;
                    end else if (n_frame == 2'd1) begin
                        n_frame     = 2'd2;
                        n_shift_out = frame_word(n_addr, n_value, 1'b0);
                        n_shift_in  = '0;
                        n_bit       = '0;
                        n_phase     = PH_DESEL;
                    end else begin
                        n_attempt   = n_attempt + 3'd1;
                        fin_set_att = 1'b1;
                        if ((payload & n_mask) == (n_value & n_mask)) begin
                            do_finish = 1'b1;
                        end else if (n_attempt >= lim) begin
                            do_finish = 1'b1;
                            fin_ok    = 1'b0;
                        end else begin
                            n_phase = PH_RETRY;
                        end
                    end
                end
            endcase
        end

        if (do_finish) begin
            n_rd_value = payload;
            n_status   = 8'(n_shift_in >> DATA_BITS);
            n_ok       = fin_ok;
            if (fin_set_att) begin
                n_att_used = n_attempt;
            end
            n_phase           = PH_IDLE;
            o_result.done_res = 1'b1;
        end

        o_result.read_value    = n_rd_value;
        o_result.status_byte   = n_status;
        o_result.verify_ok     = n_ok;
        o_result.attempts_used = n_att_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_delay     <= '0;
            r_bit       <= '0;
            r_frame     <= '0;
            r_shift_out <= '0;
            r_shift_in  <= '0;
            r_attempt   <= '0;
            r_op        <= '0;
            r_dev       <= '0;
            r_addr      <= '0;
            r_value     <= '0;
            r_mask      <= '0;
            r_rd_value  <= '0;
            r_status    <= '0;
            r_ok        <= 1'b0;
            r_att_used  <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_delay     <= n_delay;
            r_bit       <= n_bit;
            r_frame     <= n_frame;
            r_shift_out <= n_shift_out;
            r_shift_in  <= n_shift_in;
            r_attempt   <= n_attempt;
            r_op        <= n_op;
            r_dev       <= n_dev;
            r_addr      <= n_addr;
            r_value     <= n_value;
            r_mask      <= n_mask;
            r_rd_value  <= n_rd_value;
            r_status    <= n_status;
            r_ok        <= n_ok;
            r_att_used  <= n_att_used;
        end
    end

endmodule

`default_nettype wire

### rtl/spi_datagram_master_verified_unit.sv
// Top level of the SPI mode-3 datagram master: transfer handshakes, config
// registers, input and result registers. Depends on sdm_pkg and sdm_core.
`default_nettype none

// Each input transfer is one tick of the SPI pin timing and yields exactly one
// result transfer carrying that tick's sclk, mosi and cs_n pins, busy/done
// flags and the result fields of the last finished transaction. One transfer
// is taken per clock cycle while the input is not stalled; a transfer passes
// an input register, the combinational phase-sequencer logic and a result
// register. Back-pressure on the result side stalls the input only when both
// registers hold data. Config writes are registered and should only be issued
// while no transfer is in flight.
module spi_datagram_master_verified_unit
    import sdm_pkg::*;
#(
    parameter int NUM_DEVICES = NUM_DEVICES_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_bit_delay;
    logic [2:0]  r_max_attempts;
    logic        advance;
    t_out_item   core_result;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sdm_core #(
        .NUM_DEVICES (NUM_DEVICES),
        .FRAME_BITS  (FRAME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_item         (r_in),
        .i_bit_delay    (r_bit_delay),
        .i_max_attempts (r_max_attempts),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_bit_delay    <= DELAY_RESET;
            r_max_attempts <= ATTEMPTS_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BIT_DELAY:    r_bit_delay    <= i_cfg_wdata;
                    CFG_MAX_ATTEMPTS: r_max_attempts <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    a_one_cs_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones(~r_out.cs_n) <= 1)
        else $error("more than one chip select low");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_out.busy_res)
        else $error("done without busy");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |->
            (r_out.sclk && !r_out.mosi && r_out.cs_n == ALL_CS))
        else $error("pins not idle outside a transaction");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending input transfer lost");

endmodule

`default_nettype wire
